// ----- rtl/hns_pkg.sv -----
// Shared types and constants for the height map normal stencil.
// Used by the top level and the output queue; no dependencies.
package hns_pkg;

  localparam int MAX_SIDE_DEF  = 1024;
  localparam int CFG_W         = 11;
  localparam int GRID_SIDE_RST = 256;
  localparam int MIN_SIDE      = 3;
  localparam int HEIGHT_W      = 8;
  localparam int COORD_W       = 10;
  localparam int NORMAL_W      = 9;
  localparam int NY_W          = 2;

  localparam logic [NY_W-1:0] NY_INTERIOR = 2'd2;
  localparam logic [NY_W-1:0] NY_BORDER   = 2'd1;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic [HEIGHT_W-1:0]        height;
    logic signed [NORMAL_W-1:0] normal_x;
    logic [NY_W-1:0]            normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       last;
  } vertex_t;

endpackage

// ----- rtl/hns_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module hns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hns_outq.sv -----
// Two-beat output queue for vertex results; parts the compute stage from the sink.
// Depends on hns_pkg for the vertex struct.
module hns_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hns_pkg::vertex_t push_data,
  input  logic             pop,
  output hns_pkg::vertex_t head,
  output logic             head_valid,
  output logic [1:0]       count
);

  hns_pkg::vertex_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head       = entries[rd_ptr];
  assign head_valid = (count != 2'd0);

endmodule

// ----- rtl/heightmap_normal_stencil_top.sv -----
// Height map normal stencil, top level: two line stores, one compute stage, output queue.
// Path: an accepted beat is registered into stage 1, then pushed into the output queue, whose head drives the output.
// Throughput: one beat per cycle while in_stall is low, set by the single read port of each line store.
// Reset (rst, synchronous): clears counters, grid_side to 256 and the pipeline;
// line-store contents are not cleared and hold no meaning until written.
// Depends on hns_pkg, hns_ram and hns_outq.
module heightmap_normal_stencil_top #(
  parameter int MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [hns_pkg::CFG_W-1:0]           cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [hns_pkg::HEIGHT_W-1:0]        height_in,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hns_pkg::COORD_W-1:0]         row,
  output logic [hns_pkg::COORD_W-1:0]         col,
  output logic [hns_pkg::HEIGHT_W-1:0]        height_out,
  output logic signed [hns_pkg::NORMAL_W-1:0] normal_x,
  output logic [hns_pkg::NY_W-1:0]            normal_y,
  output logic signed [hns_pkg::NORMAL_W-1:0] normal_z,
  output logic                                last
);

  // Counter width indexes the line stores; side width holds the side itself
  // and is never narrower than the config register.
  localparam int CW      = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int SideRaw = $clog2(MAX_SIDE + 1);
  localparam int SideW   = (SideRaw > hns_pkg::CFG_W) ? SideRaw : hns_pkg::CFG_W;
  localparam int SideW1  = SideW + 1;
  localparam int HW      = hns_pkg::HEIGHT_W;
  localparam int CoordW  = hns_pkg::COORD_W;

  // ---------------------------------------------------------------------------
  // Configuration and effective side
  // ---------------------------------------------------------------------------
  logic [hns_pkg::CFG_W-1:0] grid_side;
  logic [SideW-1:0]          side;
  logic [SideW-1:0]          cfg_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= hns_pkg::CFG_W'(hns_pkg::GRID_SIDE_RST);
    end else if (cfg_wr_en) begin
      grid_side <= cfg_wr_data;
    end
  end

  // Clamp the side into the supported range.
  always_comb begin
    cfg_ext = SideW'(grid_side);
    if (cfg_ext < SideW'(hns_pkg::MIN_SIDE)) begin
      side = SideW'(hns_pkg::MIN_SIDE);
    end else if (cfg_ext > SideW'(MAX_SIDE)) begin
      side = SideW'(MAX_SIDE);
    end else begin
      side = cfg_ext;
    end
  end

  function automatic logic [CW-1:0] wrap_next(input logic [CW-1:0] v,
                                               input logic [SideW-1:0] s);
    logic [SideW1-1:0] v1;
    v1 = SideW1'(v) + SideW1'(1);
    return (v1 >= {1'b0, s}) ? '0 : CW'(v1);
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 0: accept a beat, advance the position, issue line-store reads
  // ---------------------------------------------------------------------------
  logic          in_accept;
  logic          in_pixel;
  logic [CW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [CW-1:0] flush_col;
  logic [CW-1:0] col_next;
  logic [CW-1:0] mid_raddr;

  assign in_accept = in_valid && !in_stall;
  assign in_pixel  = (req_type == hns_pkg::REQ_PIXEL);
  assign col_next  = wrap_next(col_count, side);

  // A pixel beat reads ahead one column in the middle line so that the next
  // pixel finds its center already fetched; a flush reads its own column.
  assign mid_raddr = in_pixel ? col_next : flush_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      flush_col <= '0;
    end else if (in_accept) begin
      if (in_pixel) begin
        col_count <= col_next;
        if (col_next == '0) begin
          row_count <= wrap_next(row_count, side);
        end
      end else begin
        flush_col <= wrap_next(flush_col, side);
      end
    end
  end

  // Stage 1 item registers; payload needs no reset.
  logic          s1_valid;
  logic          s1_flush;
  logic [CW-1:0] s1_row;
  logic [CW-1:0] s1_col;
  logic [HW-1:0] s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_flush <= !in_pixel;
      s1_row   <= row_count;
      s1_col   <= in_pixel ? col_count : flush_col;
      s1_pix   <= height_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores
  // ---------------------------------------------------------------------------
  logic          line_we;
  logic [HW-1:0] mid_rdata;
  logic [HW-1:0] up_rdata;
  logic [HW-1:0] center;

  assign line_we = s1_valid && !s1_flush;

  hns_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_SIDE)
  ) u_middle_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (in_accept),
    .raddr (mid_raddr),
    .rdata (mid_rdata)
  );

  hns_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_SIDE)
  ) u_upper_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1_col),
    .wdata (center),
    .re    (in_accept),
    .raddr (col_count),
    .rdata (up_rdata)
  );

  // Middle-line write seen by the read issued in the same cycle; a flush
  // right behind a pixel of the same column takes the new byte from here.
  logic          fwd_valid;
  logic [CW-1:0] fwd_addr;
  logic [HW-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= line_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_col;
    fwd_data <= s1_pix;
  end

  // Center byte fetched by the previous pixel beat, and that beat's center,
  // which is the value just moved into upper_line one column to the left.
  logic [HW-1:0] look_ahead;
  logic [HW-1:0] prev_center;

  assign center = look_ahead;

  always_ff @(posedge clk) begin
    if (line_we) begin
      look_ahead  <= mid_rdata;
      prev_center <= center;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: stencil arithmetic
  // ---------------------------------------------------------------------------
  logic             interior;
  logic             s1_push;
  logic [HW-1:0]    flush_height;
  hns_pkg::vertex_t vtx;

  always_comb begin
    interior = (s1_row > CW'(1))
            && (SideW'(s1_row) < side)
            && (s1_col != '0)
            && ((SideW1'(s1_col) + SideW1'(1)) < {1'b0, side});
    flush_height = (fwd_valid && (fwd_addr == s1_col)) ? fwd_data : mid_rdata;

    vtx = '0;
    if (s1_flush) begin
      vtx.row      = CoordW'(side - SideW'(1));
      vtx.col      = CoordW'(s1_col);
      vtx.height   = flush_height;
      vtx.normal_y = hns_pkg::NY_BORDER;
      vtx.last     = (SideW1'(s1_col) + SideW1'(1)) >= {1'b0, side};
    end else begin
      vtx.row    = CoordW'(s1_row - CW'(1));
      vtx.col    = CoordW'(s1_col);
      vtx.height = center;
      if (interior) begin
        vtx.normal_x = $signed({1'b0, up_rdata}) - $signed({1'b0, s1_pix});
        vtx.normal_y = hns_pkg::NY_INTERIOR;
        vtx.normal_z = $signed({1'b0, prev_center}) - $signed({1'b0, mid_rdata});
      end else begin
        vtx.normal_y = hns_pkg::NY_BORDER;
      end
    end
  end

  // Pixels of the first row produce no vertex.
  assign s1_push = s1_valid && (s1_flush || (s1_row != '0));

  // ---------------------------------------------------------------------------
  // Output queue and flow control
  // ---------------------------------------------------------------------------
  logic             out_pop;
  logic [1:0]       q_count;
  hns_pkg::vertex_t head;

  assign out_pop = out_valid && !out_stall;

  hns_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_push),
    .push_data  (vtx),
    .pop        (out_pop),
    .head       (head),
    .head_valid (out_valid),
    .count      (q_count)
  );

  // Accept only when the queue keeps a slot for this beat after the one in
  // stage 1 has landed; a beat leaving this cycle frees its slot.
  assign in_stall = ({1'b0, q_count} + 3'(s1_valid)) > (3'd1 + 3'(out_pop));

  assign row        = head.row;
  assign col        = head.col;
  assign height_out = head.height;
  assign normal_x   = head.normal_x;
  assign normal_y   = head.normal_y;
  assign normal_z   = head.normal_z;
  assign last       = head.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The queue never receives a beat it has no slot for.
  assert property (@(posedge clk) disable iff (rst)
    s1_push |-> ((q_count < 2'd2) || out_pop))
    else $error("output queue overflow");

  // The look-ahead read never hits the column being written back.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_pixel && line_we) |-> (mid_raddr != s1_col))
    else $error("middle line read-ahead collides with write-back");

  // The upper-line read never hits the column being written back.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_pixel && line_we) |-> (col_count != s1_col))
    else $error("upper line read collides with write-back");

endmodule
